// ===== hw/rtl/hsj_pkg.sv =====
// ----------------------------------------------------------------------------
// hsj_pkg
// Shared types, constants and jamo tables for the Hangul syllable to
// compatibility-jamo stream unit.
// ----------------------------------------------------------------------------
package hsj_pkg;

  // Code unit ranges
  localparam logic [15:0] SYL_FIRST      = 16'hAC00;
  localparam logic [15:0] SYL_LAST       = 16'hD7A3;
  localparam logic [15:0] JAMO_FIRST     = 16'h3131;
  localparam logic [15:0] JAMO_LAST      = 16'h3163;
  localparam logic [15:0] JAMO_LAST_CONS = 16'h314E;
  localparam logic [15:0] SEP_RESET      = 16'h3130;

  // Reciprocals for the index split: floor(x*R >> S) == floor(x/D) over range
  localparam logic [13:0] RECIP_28 = 14'd9363;  // shift 18, idx < 11172
  localparam logic [8:0]  RECIP_21 = 9'd391;    // shift 13, q < 399

  // Most units one input can cause
  localparam int unsigned MAX_RUN = 5;
  localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);
  localparam int unsigned RUN_IDX_W = $clog2(MAX_RUN);

  // Run queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Context codes
  typedef logic [1:0] ctx_t;
  localparam ctx_t CTX_NONE  = 2'd0;
  localparam ctx_t CTX_CONS  = 2'd1;
  localparam ctx_t CTX_VOWEL = 2'd2;

  typedef struct packed {
    logic [15:0] in_unit;
    logic        text_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        last_of_run;
  } out_item_t;

  // One decoded input: the units to emit, in order from entry 0
  typedef struct packed {
    logic [RUN_CNT_W-1:0]      cnt;
    logic [MAX_RUN-1:0][15:0]  units;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Second entry zero means a single jamo
  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
  } jamo_pair_t;

  function automatic logic [15:0] lead_jamo(input logic [4:0] l);
    logic [15:0] j;
    case (l)
      5'd0:    j = 16'h3131;
      5'd1:    j = 16'h3132;
      5'd2:    j = 16'h3134;
      5'd3:    j = 16'h3137;
      5'd4:    j = 16'h3138;
      5'd5:    j = 16'h3139;
      5'd6:    j = 16'h3141;
      5'd7:    j = 16'h3142;
      5'd8:    j = 16'h3143;
      5'd9:    j = 16'h3145;
      5'd10:   j = 16'h3146;
      5'd11:   j = 16'h3147;
      5'd12:   j = 16'h3148;
      5'd13:   j = 16'h3149;
      5'd14:   j = 16'h314A;
      5'd15:   j = 16'h314B;
      5'd16:   j = 16'h314C;
      5'd17:   j = 16'h314D;
      5'd18:   j = 16'h314E;
      default: j = 16'h0000;
    endcase
    return j;
  endfunction

  function automatic jamo_pair_t vowel_jamo(input logic [4:0] v);
    jamo_pair_t p;
    case (v)
      5'd0:    p = '{16'h314F, 16'h0000};
      5'd1:    p = '{16'h3150, 16'h0000};
      5'd2:    p = '{16'h3151, 16'h0000};
      5'd3:    p = '{16'h3152, 16'h0000};
      5'd4:    p = '{16'h3153, 16'h0000};
      5'd5:    p = '{16'h3154, 16'h0000};
      5'd6:    p = '{16'h3155, 16'h0000};
      5'd7:    p = '{16'h3156, 16'h0000};
      5'd8:    p = '{16'h3157, 16'h0000};
      5'd9:    p = '{16'h3157, 16'h314F};
      5'd10:   p = '{16'h3157, 16'h3150};
      5'd11:   p = '{16'h3157, 16'h3163};
      5'd12:   p = '{16'h315B, 16'h0000};
      5'd13:   p = '{16'h315C, 16'h0000};
      5'd14:   p = '{16'h315C, 16'h3153};
      5'd15:   p = '{16'h315C, 16'h3154};
      5'd16:   p = '{16'h315C, 16'h3163};
      5'd17:   p = '{16'h3160, 16'h0000};
      5'd18:   p = '{16'h3161, 16'h0000};
      5'd19:   p = '{16'h3161, 16'h3163};
      5'd20:   p = '{16'h3163, 16'h0000};
      default: p = '{16'h0000, 16'h0000};
    endcase
    return p;
  endfunction

  // Entry zero means no final
  function automatic jamo_pair_t final_jamo(input logic [4:0] t);
    jamo_pair_t p;
    case (t)
      5'd1:    p = '{16'h3131, 16'h0000};
      5'd2:    p = '{16'h3132, 16'h0000};
      5'd3:    p = '{16'h3131, 16'h3145};
      5'd4:    p = '{16'h3134, 16'h0000};
      5'd5:    p = '{16'h3134, 16'h3148};
      5'd6:    p = '{16'h3134, 16'h314E};
      5'd7:    p = '{16'h3137, 16'h0000};
      5'd8:    p = '{16'h3139, 16'h0000};
      5'd9:    p = '{16'h3139, 16'h3131};
      5'd10:   p = '{16'h3139, 16'h3141};
      5'd11:   p = '{16'h3139, 16'h3142};
      5'd12:   p = '{16'h3139, 16'h3145};
      5'd13:   p = '{16'h3139, 16'h314C};
      5'd14:   p = '{16'h3139, 16'h314D};
      5'd15:   p = '{16'h3139, 16'h314E};
      5'd16:   p = '{16'h3141, 16'h0000};
      5'd17:   p = '{16'h3142, 16'h0000};
      5'd18:   p = '{16'h3142, 16'h3145};
      5'd19:   p = '{16'h3145, 16'h0000};
      5'd20:   p = '{16'h3146, 16'h0000};
      5'd21:   p = '{16'h3147, 16'h0000};
      5'd22:   p = '{16'h3148, 16'h0000};
      5'd23:   p = '{16'h314A, 16'h0000};
      5'd24:   p = '{16'h314B, 16'h0000};
      5'd25:   p = '{16'h314C, 16'h0000};
      5'd26:   p = '{16'h314D, 16'h0000};
      5'd27:   p = '{16'h314E, 16'h0000};
      default: p = '{16'h0000, 16'h0000};
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/hsj_front.sv =====
// ----------------------------------------------------------------------------
// hsj_front
// Accepts code units, classifies them, splits syllables into jamo indexes
// over two stages and pushes one run descriptor per input into the queue.
// Holds the separator register and the consonant/vowel context.
// ----------------------------------------------------------------------------
module hsj_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsj_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               push,
  output hsj_pkg::run_t      push_data,
  input  logic               q_full
);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_SYL   = 2'd1,
    KIND_JAMO  = 2'd2
  } kind_t;

  logic [15:0]    sep_r;
  hsj_pkg::ctx_t  ctx_r;
  hsj_pkg::ctx_t  ctx_nxt;
  hsj_pkg::ctx_t  ctx_eff;

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  kind_t          s1_kind_r;
  logic [15:0]    s1_unit_r;
  logic           s1_start_r;
  logic [8:0]     s1_q28_r;
  logic [4:0]     s1_t_r;

  logic           accept;
  kind_t          kind;
  logic [15:0]    idx_full;
  logic [13:0]    idx;
  logic [27:0]    q_prod;
  logic [8:0]     q28;
  logic [13:0]    q28_x28;
  logic [13:0]    t_diff;

  logic [17:0]    l_prod;
  logic [4:0]     l_idx;
  logic [8:0]     l_x21;
  logic [8:0]     v_diff;
  logic [4:0]     v_idx;
  logic [15:0]    lead_u;
  hsj_pkg::jamo_pair_t vow_p;
  hsj_pkg::jamo_pair_t fin_p;
  logic           vd;
  logic           fd;
  logic           has_t;
  logic           is_cons;
  logic           need_sep;

  // Handshake: stage one drains whenever the queue has room
  assign push     = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming unit
  always_comb begin
    if (in_data.in_unit >= hsj_pkg::SYL_FIRST && in_data.in_unit <= hsj_pkg::SYL_LAST) begin
      kind = KIND_SYL;
    end else if (in_data.in_unit >= hsj_pkg::JAMO_FIRST &&
                 in_data.in_unit <= hsj_pkg::JAMO_LAST) begin
      kind = KIND_JAMO;
    end else begin
      kind = KIND_OTHER;
    end
  end

  // Split off the final: q28 = idx / 28, t = idx % 28
  assign idx_full = in_data.in_unit - hsj_pkg::SYL_FIRST;
  assign idx      = idx_full[13:0];
  assign q_prod   = 28'(idx) * 28'(hsj_pkg::RECIP_28);
  assign q28      = q_prod[26:18];
  assign q28_x28  = {q28, 5'b0} - {3'b0, q28, 2'b0};
  assign t_diff   = idx - q28_x28;

  // Stage one control
  assign s1_valid_nxt = accept ? 1'b1 : (push ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= kind;
      s1_unit_r  <= in_data.in_unit;
      s1_start_r <= in_data.text_start;
      s1_q28_r   <= q28;
      s1_t_r     <= t_diff[4:0];
    end
  end

  // Split lead and vowel: l = q28 / 21, v = q28 % 21
  assign l_prod = 18'(s1_q28_r) * 18'(hsj_pkg::RECIP_21);
  assign l_idx  = l_prod[17:13];
  assign l_x21  = {l_idx, 4'b0} + {2'b0, l_idx, 2'b0} + {4'b0, l_idx};
  assign v_diff = s1_q28_r - l_x21;
  assign v_idx  = v_diff[4:0];

  // Look up jamo
  assign lead_u = hsj_pkg::lead_jamo(l_idx);
  assign vow_p  = hsj_pkg::vowel_jamo(v_idx);
  assign fin_p  = hsj_pkg::final_jamo(s1_t_r);
  assign vd     = vow_p.second != 16'h0000;
  assign fd     = fin_p.second != 16'h0000;
  assign has_t  = s1_t_r != 5'd0;

  // Context seen by this unit
  assign ctx_eff  = s1_start_r ? hsj_pkg::CTX_NONE : ctx_r;
  assign is_cons  = s1_unit_r <= hsj_pkg::JAMO_LAST_CONS;
  assign need_sep = (ctx_eff == hsj_pkg::CTX_VOWEL && is_cons) ||
                    (ctx_eff == hsj_pkg::CTX_CONS && !is_cons);

  // Build the run descriptor and the next context
  always_comb begin
    push_data.units = '0;
    push_data.cnt   = hsj_pkg::RUN_CNT_W'(1);
    ctx_nxt         = hsj_pkg::CTX_NONE;
    case (s1_kind_r)
      KIND_SYL: begin
        push_data.units[0] = lead_u;
        push_data.units[1] = vow_p.first;
        if (vd) begin
          push_data.units[2] = vow_p.second;
          push_data.units[3] = fin_p.first;
          push_data.units[4] = fin_p.second;
        end else begin
          push_data.units[2] = fin_p.first;
          push_data.units[3] = fin_p.second;
        end
        push_data.cnt = hsj_pkg::RUN_CNT_W'(2) + hsj_pkg::RUN_CNT_W'(vd) +
                        hsj_pkg::RUN_CNT_W'(has_t) + hsj_pkg::RUN_CNT_W'(fd);
        ctx_nxt = has_t ? hsj_pkg::CTX_CONS : hsj_pkg::CTX_VOWEL;
      end
      KIND_JAMO: begin
        if (need_sep) begin
          push_data.units[0] = sep_r;
          push_data.units[1] = s1_unit_r;
          push_data.cnt      = hsj_pkg::RUN_CNT_W'(2);
        end else begin
          push_data.units[0] = s1_unit_r;
        end
        ctx_nxt = ctx_eff;
      end
      default: begin
        push_data.units[0] = s1_unit_r;
        ctx_nxt            = hsj_pkg::CTX_NONE;
      end
    endcase
  end

  // Update context and separator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= hsj_pkg::CTX_NONE;
      sep_r <= hsj_pkg::SEP_RESET;
    end else begin
      if (push) begin
        ctx_r <= ctx_nxt;
      end
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
    end
  end

endmodule

// ===== hw/rtl/hsj_queue.sv =====
// ----------------------------------------------------------------------------
// hsj_queue
// Short FIFO of run descriptors between the front and the back.
// ----------------------------------------------------------------------------
module hsj_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hsj_pkg::run_t       push_data,
  input  logic                pop,
  output hsj_pkg::run_t       head,
  output hsj_pkg::q_status_t  status
);

  localparam logic [hsj_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    hsj_pkg::QUEUE_PTR_W'(hsj_pkg::QUEUE_DEPTH - 1);

  hsj_pkg::run_t                    mem_r [hsj_pkg::QUEUE_DEPTH];
  logic [hsj_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [hsj_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [hsj_pkg::QUEUE_CNT_W-1:0]  count_r;
  logic [hsj_pkg::QUEUE_CNT_W-1:0]  count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = count_r == hsj_pkg::QUEUE_CNT_W'(hsj_pkg::QUEUE_DEPTH);
  assign status.empty = count_r == '0;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/hsj_back.sv =====
// ----------------------------------------------------------------------------
// hsj_back
// Walks the run at the head of the queue one unit per beat into the
// output register and pops the run as its last unit is loaded.
// ----------------------------------------------------------------------------
module hsj_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hsj_pkg::run_t       head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output hsj_pkg::out_item_t  out_data
);

  logic [hsj_pkg::RUN_IDX_W-1:0]  pos_r;
  logic [hsj_pkg::RUN_IDX_W-1:0]  pos_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  hsj_pkg::out_item_t             out_data_r;
  logic                           load;
  logic                           last;

  assign load = !q_empty && (!out_valid_r || out_ready);
  assign last = hsj_pkg::RUN_CNT_W'(pos_r) == head.cnt - 1'b1;
  assign pop  = load && last;

  assign pos_nxt       = load ? (last ? '0 : pos_r + 1'b1) : pos_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Advance position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the next unit
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_unit    <= head.units[pos_r];
      out_data_r.last_of_run <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/hangul_syllable_to_jamo_stream_unit.sv =====
// ----------------------------------------------------------------------------
// hangul_syllable_to_jamo_stream_unit
// Splits Hangul syllables into compatibility jamo, separates lone jamo that
// would merge, and passes other UTF-16 units through.
// ----------------------------------------------------------------------------
// Path: an input beat passes the stage one register, the queue and the output register.
// Throughput: one result per cycle while out_ready is high; an input causes 1 to 5 results,
//   walked out one at a time through the single output register.
// Reset: synchronous active low; clears context, queue and valids, and sets
//   the separator to 0x3130.
module hangul_syllable_to_jamo_stream_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsj_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsj_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic                push;
  hsj_pkg::run_t       push_data;
  logic                pop;
  hsj_pkg::run_t       head;
  hsj_pkg::q_status_t  q_stat;

  hsj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_stat.full)
  );

  hsj_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_stat)
  );

  hsj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("run pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("run popped from empty queue");

  // Every queued run holds one to five units
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (head.cnt >= hsj_pkg::RUN_CNT_W'(1) &&
                       head.cnt <= hsj_pkg::RUN_CNT_W'(hsj_pkg::MAX_RUN)))
    else $error("queued run has bad length");

  // Input stalls only on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.full) else $error("input stalled without full queue");

endmodule
